[design/bmc_pkg.sv]
// bmc_pkg: shared types, codes and the character decoder for the bracket checker
// used by bmc_ctrl, bmc_datapath and bracket_match_completion_score
// no dependencies
package bmc_pkg;

    // input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // line status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CORRUPT  = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // bracket kind codes
    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    // bracket characters
    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_REFILL,
        S_DRAIN,
        S_FINISH
    } state_t;

    // decoded character
    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } sym_class_t;

    // controller to datapath commands
    typedef struct packed {
        logic char_step;
        logic load_top;
        logic eol_start;
        logic drain;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pop_hit;
        logic drain_busy;
        logic out_busy;
    } dp_status_t;

    // classify one character byte
    function automatic sym_class_t classify(input logic [7:0] ch);
        sym_class_t c;
        c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
        unique case (ch)
            CH_OPEN_PAREN:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
            CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
            CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
            CH_OPEN_ANGLE:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
            CH_CLOSE_PAREN:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
            CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
            CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
            CH_CLOSE_ANGLE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
            default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
        endcase
        return c;
    endfunction

endpackage

[design/bmc_ctrl.sv]
// bmc_ctrl: sequencing state machine for the bracket checker
// depends on bmc_pkg for state, command and status types
module bmc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                command,
    output logic                item_stall,
    output bmc_pkg::ctrl_cmd_t  cmd,
    input  bmc_pkg::dp_status_t status
);
    import bmc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (command == CMD_EOL)
                    begin
                        state_next = S_DRAIN;
                    end
                    else if (status.pop_hit)
                    begin
                        state_next = S_REFILL;
                    end
                end
            end
            S_REFILL:
            begin
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                if (!status.drain_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall    = 1'b0;
                cmd.char_step = item_valid && (command == CMD_CHAR);
                cmd.eol_start = item_valid && (command == CMD_EOL);
            end
            S_REFILL:
            begin
                cmd.load_top = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.drain = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[design/bmc_datapath.sv]
// bmc_datapath: bracket stack memory, fault tracking, score accumulator and result register
// depends on bmc_pkg for codes, the character decoder and command/status types
module bmc_datapath
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          symbol,
    input  bmc_pkg::ctrl_cmd_t  cmd,
    output bmc_pkg::dp_status_t status,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          line_status,
    output logic [63:0]         score,
    output logic [7:0]          open_count
);
    import bmc_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    // stack storage
    logic [1:0]    stack_mem [STACK_DEPTH];
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic [1:0]    rd_data_reg;

    logic [DW-1:0] depth_reg, depth_next;
    logic [1:0]    fault_reg, fault_next;
    logic [1:0]    top_reg, top_next;
    logic [DW-1:0] walk_reg, walk_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [63:0]   acc_reg, acc_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    line_status_reg;
    logic [63:0]   score_reg;
    logic [7:0]    open_count_reg;

    sym_class_t    sym;
    logic          depth_full;
    logic          depth_zero;
    logic [DW-1:0] depth_dec;
    logic [DW-1:0] depth_dec2;
    logic [DW-1:0] walk_dec;

    assign sym        = classify(symbol);
    assign depth_full = (depth_reg == DW'(STACK_DEPTH));
    assign depth_zero = (depth_reg == '0);
    assign depth_dec  = depth_reg - DW'(1);
    assign depth_dec2 = depth_reg - DW'(2);
    assign walk_dec   = walk_reg - DW'(1);

    // status to the controller
    assign status.pop_hit    = (fault_reg == ST_OK) && sym.is_close && !depth_zero
                               && (top_reg == sym.kind);
    assign status.drain_busy = (walk_reg != '0) || rd_pend_reg;
    assign status.out_busy   = out_valid_reg && result_stall;

    // memory port control: push writes, refill or drain reads
    always_comb
    begin
        wr_en  = cmd.char_step && (fault_reg == ST_OK) && sym.is_open && !depth_full;
        wr_idx = depth_reg[IW-1:0];
        rd_en  = 1'b0;
        rd_idx = walk_dec[IW-1:0];
        if (cmd.char_step && status.pop_hit && (depth_reg >= DW'(2)))
        begin
            rd_en  = 1'b1;
            rd_idx = depth_dec2[IW-1:0];
        end
        else if (cmd.drain && (walk_reg != '0))
        begin
            rd_en  = 1'b1;
            rd_idx = walk_dec[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_idx] <= sym.kind;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_idx];
        end
    end

    // line processing, scoring walk and result load
    always_comb
    begin
        depth_next     = depth_reg;
        fault_next     = fault_reg;
        top_next       = top_reg;
        walk_next      = walk_reg;
        rd_pend_next   = rd_pend_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (cmd.char_step && (fault_reg == ST_OK))
        begin
            if (sym.is_open)
            begin
                if (depth_full)
                begin
                    fault_next = ST_OVERFLOW;
                end
                else
                begin
                    depth_next = depth_reg + DW'(1);
                    top_next   = sym.kind;
                end
            end
            else if (sym.is_close)
            begin
                if (status.pop_hit)
                begin
                    depth_next = depth_dec;
                end
                else
                begin
                    fault_next = ST_CORRUPT;
                end
            end
            else
            begin
                fault_next = ST_INVALID;
            end
        end

        if (cmd.load_top)
        begin
            top_next = rd_data_reg;
        end

        if (cmd.eol_start)
        begin
            walk_next    = (fault_reg == ST_OK) ? depth_reg : '0;
            rd_pend_next = 1'b0;
            acc_next     = '0;
        end

        // score = score * 5 + kind + 1, one stack entry a cycle
        if (cmd.drain)
        begin
            rd_pend_next = (walk_reg != '0);
            if (walk_reg != '0)
            begin
                walk_next = walk_dec;
            end
            if (rd_pend_reg)
            begin
                acc_next = {acc_reg[61:0], 2'b00} + acc_reg + {62'd0, rd_data_reg} + 64'd1;
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            depth_next     = '0;
            fault_next     = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            fault_reg     <= ST_OK;
            walk_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            fault_reg     <= fault_next;
            walk_reg      <= walk_next;
            rd_pend_reg   <= rd_pend_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // top of stack cache and result payload
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.finish)
        begin
            line_status_reg <= fault_reg;
            score_reg       <= acc_reg;
            open_count_reg  <= 8'(depth_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign line_status  = line_status_reg;
    assign score        = score_reg;
    assign open_count   = open_count_reg;

`ifndef NO_ASSERTIONS
    // stack never grows past its depth
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // a finished line leaves the stack empty and the line clean
    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (depth_reg == '0) && (fault_reg == ST_OK))
        else $error("line state not cleared after result");

    // a faulted line reports a zero score
    a_fault_score: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (line_status != ST_OK)) |-> (score == 64'd0))
        else $error("nonzero score on faulted line");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && result_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

[design/bracket_match_completion_score.sv]
// bracket_match_completion_score: top level, checks bracket balance per line and scores
// completions; depends on bmc_pkg, bmc_ctrl and bmc_datapath
// timing: a character is handled in the cycle it is taken; a matching closer also passes
// through the refill state (top of stack refill read) before the next transfer is taken
// end of line: the drain state walks the open brackets of a clean line (one stack read per
// cycle), then finish loads the result, which waits on a stalled result; then transfers resume
// reset: rst_n asynchronous active low, clears stack depth, line fault and result valid
module bracket_match_completion_score
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        command,
    input  logic [7:0]  symbol,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  line_status,
    output logic [63:0] score,
    output logic [7:0]  open_count
);
    import bmc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    bmc_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (command),
        .item_stall (item_stall),
        .cmd        (cmd),
        .status     (status)
    );

    // stack, scoring and result
    bmc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol       (symbol),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .line_status  (line_status),
        .score        (score),
        .open_count   (open_count)
    );

endmodule
